// File: hdl/gtq_pkg.sv
`default_nettype none
package gtq_pkg;
  localparam int unsigned TeamW = 8;
  localparam int unsigned ElemW = 12;
  localparam int unsigned SlotW = 10;
  localparam int unsigned Teams = 2 ** TeamW;
  localparam int unsigned Elements = 2 ** ElemW;
  localparam int unsigned Capacity = 2 ** SlotW;

  typedef enum logic [1:0] {
    REQ_ASSIGN  = 2'd0,
    REQ_ENQUEUE = 2'd1,
    REQ_DEQUEUE = 2'd2,
    REQ_CLEAR   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOTEAM = 2'd3
  } status_e;

  typedef struct packed {
    req_e              req;
    logic [ElemW-1:0]  elem;
    logic [TeamW-1:0]  team;
  } cmd_t;

  typedef struct packed {
    status_e           status;
    logic [ElemW-1:0]  elem;
    logic              valid;
  } res_t;

  typedef enum logic [3:0] {
    B_CLR,
    B_IDLE,
    B_ASG_RD,
    B_ASG_WR,
    B_ENQ_RD,
    B_ENQ_RD2,
    B_ENQ_WR,
    B_DEQ_RD,
    B_DEQ_RD2,
    B_DEQ_RD3,
    B_DEQ_WR,
    B_OUT
  } back_e;
endpackage
`default_nettype wire

// File: hdl/gtq_front.sv
`default_nettype none
module gtq_front (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire gtq_pkg::cmd_t in_cmd_i,
  output logic              q_valid_o,
  input  wire               q_pop_i,
  output gtq_pkg::cmd_t     q_cmd_o
);
  import gtq_pkg::*;

  cmd_t       buf_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;
  logic       push;

  assign in_stall_o = (cnt_q == 2'd2);
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_cmd_o    = buf_q[rd_q];

  always_comb begin
    wr_d  = push ? !wr_q : wr_q;
    rd_d  = q_pop_i ? !rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push} - {1'b0, q_pop_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) buf_q[wr_q] <= in_cmd_i;
  end
endmodule
`default_nettype wire

// File: hdl/gtq_back.sv
`default_nettype none
module gtq_back (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                q_valid_i,
  output logic               q_pop_o,
  input  wire gtq_pkg::cmd_t q_cmd_i,
  output logic               res_valid_o,
  input  wire                res_stall_i,
  output gtq_pkg::res_t      res_o,
  output logic               busy_clear_o
);
  import gtq_pkg::*;

  // team_of_element: TeamW+1 bits, top bit set means no team
  logic [TeamW:0]   toe_mem [Elements];
  logic [SlotW-1:0] head_mem [Teams];
  logic [SlotW-1:0] tail_mem [Teams];
  logic [ElemW-1:0] selem_mem [Capacity];
  logic [SlotW-1:0] snext_mem [Capacity];
  logic [SlotW-1:0] free_mem [Capacity];
  logic [TeamW-1:0] ord_mem [Teams];
  logic [Teams-1:0] active_q;

  back_e            st_q, st_d;
  cmd_t             cmd_q;
  res_t             res_q, res_d;
  logic [ElemW:0]   clr_q, clr_d;
  logic             clr_rsp_q, clr_rsp_d;
  logic [SlotW:0]   free_cnt_q, free_cnt_d;
  logic [TeamW-1:0] ord_head_q, ord_head_d, ord_tail_q, ord_tail_d;
  logic [TeamW:0]   ord_cnt_q, ord_cnt_d;

  logic [TeamW:0]   toe_rd_q;
  logic [SlotW-1:0] free_rd_q, head_rd_q, tail_rd_q, snext_rd_q;
  logic [TeamW-1:0] ord_rd_q;
  logic [ElemW-1:0] selem_rd_q;

  logic             toe_we;
  logic [TeamW:0]   toe_wd;
  logic [ElemW-1:0] toe_wa;
  logic             head_we, tail_we, selem_we, snext_we, free_we, ord_we;
  logic [TeamW-1:0] ht_wa;
  logic [SlotW-1:0] head_wd, tail_wd, snext_wa, snext_wd, free_wa, free_wd;
  logic [TeamW-1:0] team_r;
  logic [SlotW-1:0] slot_r;
  logic             act_set, act_clr;
  logic             deq_rd;

  assign res_valid_o  = (st_q == B_OUT);
  assign res_o        = res_q;
  assign busy_clear_o = (st_q == B_CLR);
  assign team_r       = toe_rd_q[TeamW-1:0];
  assign deq_rd       = (st_q == B_DEQ_RD2) || (st_q == B_DEQ_RD3);

  always_comb begin
    st_d = st_q;  res_d = res_q;  clr_d = clr_q;  clr_rsp_d = clr_rsp_q;
    free_cnt_d = free_cnt_q;  ord_head_d = ord_head_q;
    ord_tail_d = ord_tail_q;  ord_cnt_d = ord_cnt_q;
    q_pop_o = 1'b0;
    toe_we = 1'b0;  toe_wa = cmd_q.elem;  toe_wd = toe_rd_q;
    head_we = 1'b0;  tail_we = 1'b0;  ht_wa = team_r;
    head_wd = free_rd_q;  tail_wd = free_rd_q;
    selem_we = 1'b0;  snext_we = 1'b0;  snext_wa = free_rd_q;  snext_wd = '0;
    free_we = 1'b0;  free_wa = free_cnt_q[SlotW-1:0];  free_wd = clr_q[SlotW-1:0];
    ord_we = 1'b0;  act_set = 1'b0;  act_clr = 1'b0;
    slot_r = head_rd_q;
    unique case (st_q)
      B_CLR: begin
        toe_we = 1'b1;
        toe_wa = clr_q[ElemW-1:0];
        toe_wd = {1'b1, {TeamW{1'b0}}};
        if (clr_q < (ElemW+1)'(Capacity)) free_we = 1'b1;
        free_wa = clr_q[SlotW-1:0];
        clr_d = clr_q + 1'b1;
        if (clr_q == (ElemW+1)'(Elements - 1)) begin
          st_d = clr_rsp_q ? B_OUT : B_IDLE;
        end
      end
      B_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          res_d = '{status: ST_OK, elem: '0, valid: 1'b0};
          unique case (q_cmd_i.req)
            REQ_ASSIGN:  st_d = B_ASG_RD;
            REQ_ENQUEUE: st_d = B_ENQ_RD;
            REQ_DEQUEUE: begin
              if (ord_cnt_q == '0) begin
                res_d.status = ST_EMPTY;
                st_d = B_OUT;
              end else begin
                st_d = B_DEQ_RD;
              end
            end
            default: begin
              clr_d = '0;  free_cnt_d = (SlotW+1)'(Capacity);
              ord_head_d = '0;  ord_tail_d = '0;  ord_cnt_d = '0;
              act_clr = 1'b1;  clr_rsp_d = 1'b1;
              st_d = B_CLR;
            end
          endcase
        end
      end
      B_ASG_RD: st_d = B_ASG_WR;
      B_ASG_WR: begin
        if ({1'b0, cmd_q.team} < toe_rd_q) begin
          toe_we = 1'b1;
          toe_wd = {1'b0, cmd_q.team};
        end
        st_d = B_OUT;
      end
      B_ENQ_RD: begin
        if (toe_rd_q[TeamW]) begin
          res_d.status = ST_NOTEAM;  st_d = B_OUT;
        end else if (free_cnt_q == '0) begin
          res_d.status = ST_FULL;  st_d = B_OUT;
        end else begin
          free_cnt_d = free_cnt_q - 1'b1;
          st_d = B_ENQ_RD2;
        end
      end
      B_ENQ_RD2: st_d = B_ENQ_WR;
      B_ENQ_WR: begin
        selem_we = 1'b1;  snext_we = 1'b1;  tail_we = 1'b1;
        if (active_q[team_r]) begin
          snext_wa = tail_rd_q;  snext_wd = free_rd_q;
          // own next cleared by a second write below is unneeded: next of tail never read
        end else begin
          snext_we = 1'b0;  head_we = 1'b1;  act_set = 1'b1;
          ord_we = 1'b1;
          ord_tail_d = ord_tail_q + 1'b1;
          ord_cnt_d = ord_cnt_q + 1'b1;
        end
        st_d = B_OUT;
      end
      B_DEQ_RD:  st_d = B_DEQ_RD2;
      B_DEQ_RD2: st_d = B_DEQ_RD3;
      B_DEQ_RD3: st_d = B_DEQ_WR;
      B_DEQ_WR: begin
        res_d = '{status: ST_OK, elem: selem_rd_q, valid: 1'b1};
        free_we = 1'b1;  free_wd = head_rd_q;
        free_cnt_d = free_cnt_q + 1'b1;
        ht_wa = ord_rd_q;
        if (head_rd_q == tail_rd_q) begin
          act_clr = 1'b0;
          ord_head_d = ord_head_q + 1'b1;
          ord_cnt_d = ord_cnt_q - 1'b1;
        end else begin
          head_we = 1'b1;  head_wd = snext_rd_q;
        end
        st_d = B_OUT;
      end
      B_OUT: if (!res_stall_i) st_d = B_IDLE;
      default: st_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_CLR;
      clr_q <= '0;
      clr_rsp_q <= 1'b0;
      free_cnt_q <= (SlotW+1)'(Capacity);
      ord_head_q <= '0;  ord_tail_q <= '0;  ord_cnt_q <= '0;
      active_q <= '0;
      res_q <= '{status: ST_OK, elem: '0, valid: 1'b0};
    end else begin
      st_q <= st_d;  clr_q <= clr_d;  clr_rsp_q <= clr_rsp_d;  free_cnt_q <= free_cnt_d;
      ord_head_q <= ord_head_d;  ord_tail_q <= ord_tail_d;  ord_cnt_q <= ord_cnt_d;
      res_q <= res_d;
      if (act_clr && st_q == B_IDLE) active_q <= '0;
      else if (act_set) active_q[team_r] <= 1'b1;
      else if (st_q == B_DEQ_WR && head_rd_q == tail_rd_q) active_q[ord_rd_q] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == B_IDLE && q_valid_i) cmd_q <= q_cmd_i;
    toe_rd_q <= toe_mem[(st_q == B_IDLE) ? q_cmd_i.elem : cmd_q.elem];
    if (toe_we) toe_mem[toe_wa] <= toe_wd;
    free_rd_q <= free_mem[free_cnt_q[SlotW-1:0]];
    if (free_we) free_mem[free_wa] <= free_wd;
    ord_rd_q <= ord_mem[ord_head_q];
    if (ord_we) ord_mem[ord_tail_q] <= team_r;
    head_rd_q <= head_mem[deq_rd ? ord_rd_q : team_r];
    tail_rd_q <= tail_mem[deq_rd ? ord_rd_q : team_r];
    if (head_we) head_mem[ht_wa] <= head_wd;
    if (tail_we) tail_mem[ht_wa] <= tail_wd;
    selem_rd_q <= selem_mem[slot_r];
    snext_rd_q <= snext_mem[slot_r];
    if (selem_we) selem_mem[free_rd_q] <= cmd_q.elem;
    if (snext_we) snext_mem[snext_wa] <= snext_wd;
  end
endmodule
`default_nettype wire

// File: hdl/grouped_team_queue.sv
`default_nettype none
// channel | signals                                   | direction
// request | req_valid_i req_stall_o req_type_i element_id_i team_id_i | in
// result  | res_valid_o res_stall_i status_o element_out_o element_valid_o | out
// Sequencer path to the result word: assign ASG_RD, ASG_WR; enqueue ENQ_RD,
// ENQ_RD2, ENQ_WR; dequeue DEQ_RD to DEQ_WR; rejected enqueue ENQ_RD; empty dequeue none.
// A two-word queue parts request intake from the executing sequencer.
// After reset and after clear all, a clear pass over all 4096 elements empties the team map.
// The result register holds under res_stall_i; requests queue meanwhile.
module grouped_team_queue (
  input  wire        clk_i,
  input  wire        rst_ni,
  input  wire        req_valid_i,
  output logic       req_stall_o,
  input  wire [1:0]  req_type_i,
  input  wire [11:0] element_id_i,
  input  wire [7:0]  team_id_i,
  output logic       res_valid_o,
  input  wire        res_stall_i,
  output logic [1:0] status_o,
  output logic [11:0] element_out_o,
  output logic       element_valid_o
);
  import gtq_pkg::*;

  cmd_t in_cmd, q_cmd;
  res_t res;
  logic q_valid, q_pop, busy_clear;

  assign in_cmd = '{req: req_e'(req_type_i), elem: element_id_i, team: team_id_i};

  gtq_front u_front (
    .clk_i, .rst_ni,
    .in_valid_i(req_valid_i), .in_stall_o(req_stall_o), .in_cmd_i(in_cmd),
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  gtq_back u_back (
    .clk_i, .rst_ni,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .res_valid_o(res_valid_o), .res_stall_i(res_stall_i), .res_o(res),
    .busy_clear_o(busy_clear)
  );

  assign status_o        = res.status;
  assign element_out_o   = res.elem;
  assign element_valid_o = res.valid;

  a_no_pop_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_clear |-> !q_pop) else $error("pop during clear");
  a_valid_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && element_valid_o |-> status_o == ST_OK) else $error("bad status");
  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("pop from empty");
endmodule
`default_nettype wire
